>>> sv/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants for the grid bilinear sampler.
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_ELEV  = 2'd1;
  localparam logic [1:0] ACT_WATER = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [2:0] CFG_AREA_MIN_X    = 3'd0;
  localparam logic [2:0] CFG_AREA_MIN_Y    = 3'd1;
  localparam logic [2:0] CFG_SCALE_X       = 3'd2;
  localparam logic [2:0] CFG_SCALE_Y       = 3'd3;
  localparam logic [2:0] CFG_BUMP_CENTER_X = 3'd4;
  localparam logic [2:0] CFG_BUMP_CENTER_Y = 3'd5;
  localparam logic [2:0] CFG_BUMP_RADIUS   = 3'd6;

  // 50.0 in Q24.8
  localparam logic [36:0] BUMP_HEIGHT = 37'd12800;
  localparam logic [36:0] SAT_MAX     = 37'h0_7FFF_FFFF;

  localparam int ADDR_W = 16;

  typedef struct packed {
    logic [1:0]         action;
    logic [15:0]        cell_index;
    logic signed [31:0] cell_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               land_error;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] area_min_x;
    logic signed [31:0] area_min_y;
    logic [31:0]        scale_x;
    logic [31:0]        scale_y;
    logic signed [31:0] bump_center_x;
    logic signed [31:0] bump_center_y;
    logic [30:0]        bump_radius;
  } cfg_t;

  // front to back: one classified, address-resolved item
  typedef struct packed {
    logic               valid;
    logic [1:0]         action;
    logic [15:0]        cell_index;
    logic signed [31:0] cell_value;
    logic [ADDR_W-1:0]  addr_ll;
    logic [ADDR_W-1:0]  addr_lr;
    logic [ADDR_W-1:0]  addr_ul;
    logic [ADDR_W-1:0]  addr_ur;
    logic [8:0]         wx;
    logic [8:0]         wy;
    logic               in_range;
    logic [61:0]        sq_x;
    logic [61:0]        sq_y;
    logic [61:0]        sq_r;
  } fb_t;

endpackage

>>> sv/grid_bilinear_sampler_core.sv
// ----------------------------------------------------------------------------
// grid_bilinear_sampler_core
// Loads an elevation grid and answers bilinear elevation / water queries.
//
//   channel | ports                           | handshake
//   input   | push, full, in_word             | push & !full
//   result  | empty, pop, out_word            | pop & !empty
//   config  | cfg_valid, cfg_ready, cfg_index,| cfg_valid & cfg_ready
//           | cfg_data                        |
//
// One word accepted per cycle while full is low; a query result is written to
// the queue after the last stage below and can then be popped. Stages: input
// register, offsets, scale multiply, cell address and weights, grid RAM read,
// row blend, column blend.
// full rises once 16 query results are in flight or queued; loads take no slot.
// Reset clears control and config only; grid store undefined until loaded.
// Config writes are always ready and apply immediately.
// ----------------------------------------------------------------------------
module grid_bilinear_sampler_core #(
  parameter int GRID_W = 256,
  parameter int GRID_H = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  gbs_pkg::in_word_t  in_word,
  output logic               empty,
  input  logic               pop,
  output gbs_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int QDEPTH = 16;
  localparam int CW     = $clog2(QDEPTH) + 1;

  gbs_pkg::cfg_t      cfg_r;
  gbs_pkg::fb_t       fb;
  gbs_pkg::out_word_t res_word;
  logic               res_push;
  logic               fifo_full;
  logic [CW-1:0]      fifo_cnt;
  logic [CW-1:0]      resv_r, resv_nxt;
  logic               acc_in, acc_q, pop_ok;

  assign cfg_ready = 1'b1;
  assign full      = (resv_r == CW'(QDEPTH));
  assign acc_in    = push && !full;
  assign acc_q     = acc_in && ((in_word.action == gbs_pkg::ACT_ELEV)
                             || (in_word.action == gbs_pkg::ACT_WATER));
  assign pop_ok    = pop && !empty;
  assign resv_nxt  = resv_r + CW'(acc_q) - CW'(pop_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r  <= '0;
      resv_r <= '0;
    end else begin
      resv_r <= resv_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gbs_pkg::CFG_AREA_MIN_X:    cfg_r.area_min_x    <= cfg_data;
          gbs_pkg::CFG_AREA_MIN_Y:    cfg_r.area_min_y    <= cfg_data;
          gbs_pkg::CFG_SCALE_X:       cfg_r.scale_x       <= cfg_data;
          gbs_pkg::CFG_SCALE_Y:       cfg_r.scale_y       <= cfg_data;
          gbs_pkg::CFG_BUMP_CENTER_X: cfg_r.bump_center_x <= cfg_data;
          gbs_pkg::CFG_BUMP_CENTER_Y: cfg_r.bump_center_y <= cfg_data;
          gbs_pkg::CFG_BUMP_RADIUS:   cfg_r.bump_radius   <= cfg_data[30:0];
          default: ;
        endcase
      end
    end
  end

  gbs_front #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_front (
    .clk(clk), .rst_n(rst_n), .acc_in(acc_in), .in_word(in_word),
    .cfg(cfg_r), .fb(fb));

  gbs_back #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_back (
    .clk(clk), .rst_n(rst_n), .fb(fb), .res_push(res_push),
    .res_word(res_word));

  gbs_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(res_push), .push_word(res_word),
    .pop(pop), .empty(empty), .fifo_full(fifo_full), .count(fifo_cnt),
    .head(out_word));

`ifndef SYNTHESIS
  a_resv_covers_queue: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt <= resv_r) else $error("queue holds more words than reserved");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_push && fifo_full) || pop_ok) else $error("result queue overflow");

  a_resv_count: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_q && !pop_ok) |=> (resv_r == $past(resv_r) + 1'b1))
    else $error("reservation count slipped");
`endif

endmodule

>>> sv/gbs_ram.sv
// ----------------------------------------------------------------------------
// gbs_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module gbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/gbs_front.sv
// ----------------------------------------------------------------------------
// gbs_front
// Takes words in, maps query points to grid cells and weights, circle terms.
// ----------------------------------------------------------------------------
module gbs_front #(
  parameter int GRID_W = 256,
  parameter int GRID_H = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc_in,
  input  gbs_pkg::in_word_t in_word,
  input  gbs_pkg::cfg_t    cfg,
  output gbs_pkg::fb_t     fb
);

  localparam int XCW = $clog2(GRID_W + 1) + 8;
  localparam int YCW = $clog2(GRID_H + 1) + 8;
  localparam int XIW = XCW - 8;
  localparam int YIW = YCW - 8;

  // stage 0
  logic              s0_v_r;
  gbs_pkg::in_word_t s0_w_r;
  logic signed [32:0] dx, dy, cdx, cdy;

  // stage 1
  logic              s1_v_r;
  gbs_pkg::in_word_t s1_w_r;
  logic signed [32:0] s1_dx_r, s1_dy_r, s1_cdx_r, s1_cdy_r;
  logic [32:0]       ax, ay;
  logic              posx, posy;

  // stage 2
  logic              s2_v_r;
  gbs_pkg::in_word_t s2_w_r;
  logic [63:0]       s2_px_r, s2_py_r;
  logic              s2_posx_r, s2_posy_r, s2_inr_r;
  logic [30:0]       s2_ax_r, s2_ay_r;
  logic [XCW-1:0]    cx;
  logic [YCW-1:0]    cy;
  logic [XIW-1:0]    lx, rx;
  logic [YIW-1:0]    ly, uy;
  logic [31:0]       row_l, row_u;

  gbs_pkg::fb_t fb_r, fb_nxt;

  assign dx  = $signed({s0_w_r.query_x[31], s0_w_r.query_x})
             - $signed({cfg.area_min_x[31], cfg.area_min_x});
  assign dy  = $signed({s0_w_r.query_y[31], s0_w_r.query_y})
             - $signed({cfg.area_min_y[31], cfg.area_min_y});
  assign cdx = $signed({s0_w_r.query_x[31], s0_w_r.query_x})
             - $signed({cfg.bump_center_x[31], cfg.bump_center_x});
  assign cdy = $signed({s0_w_r.query_y[31], s0_w_r.query_y})
             - $signed({cfg.bump_center_y[31], cfg.bump_center_y});

  assign ax   = s1_cdx_r[32] ? 33'(-s1_cdx_r) : 33'(s1_cdx_r);
  assign ay   = s1_cdy_r[32] ? 33'(-s1_cdy_r) : 33'(s1_cdy_r);
  assign posx = !s1_dx_r[32] && (s1_dx_r != '0) && (cfg.scale_x != '0);
  assign posy = !s1_dy_r[32] && (s1_dy_r != '0) && (cfg.scale_y != '0);

  always_comb begin
    // grid coordinate, 8 fraction bits, saturated at the grid edge
    if (!s2_posx_r) begin
      cx = '0;
    end else if (s2_px_r[63:32] >= 32'(GRID_W)) begin
      cx = XCW'(GRID_W * 256);
    end else begin
      cx = s2_px_r[24 +: XCW];
    end
    if (!s2_posy_r) begin
      cy = '0;
    end else if (s2_py_r[63:32] >= 32'(GRID_H)) begin
      cy = YCW'(GRID_H * 256);
    end else begin
      cy = s2_py_r[24 +: YCW];
    end
    lx = cx[XCW-1:8];
    rx = lx + XIW'(cx[7:0] != '0);
    ly = cy[YCW-1:8];
    uy = ly + YIW'(cy[7:0] != '0);
    if (lx > XIW'(GRID_W - 1)) lx = XIW'(GRID_W - 1);
    if (rx > XIW'(GRID_W - 1)) rx = XIW'(GRID_W - 1);
    if (ly > YIW'(GRID_H - 1)) ly = YIW'(GRID_H - 1);
    if (uy > YIW'(GRID_H - 1)) uy = YIW'(GRID_H - 1);
    row_l = 32'(ly) * 32'(GRID_W);
    row_u = 32'(uy) * 32'(GRID_W);

    fb_nxt            = fb_r;
    fb_nxt.valid      = s2_v_r;
    fb_nxt.action     = s2_w_r.action;
    fb_nxt.cell_index = s2_w_r.cell_index;
    fb_nxt.cell_value = s2_w_r.cell_value;
    fb_nxt.addr_ll    = gbs_pkg::ADDR_W'(row_l + 32'(lx));
    fb_nxt.addr_lr    = gbs_pkg::ADDR_W'(row_l + 32'(rx));
    fb_nxt.addr_ul    = gbs_pkg::ADDR_W'(row_u + 32'(lx));
    fb_nxt.addr_ur    = gbs_pkg::ADDR_W'(row_u + 32'(rx));
    fb_nxt.wx         = 9'(cx - {lx, 8'd0});
    fb_nxt.wy         = 9'(cy - {ly, 8'd0});
    fb_nxt.in_range   = s2_inr_r;
    fb_nxt.sq_x       = 62'(s2_ax_r) * 62'(s2_ax_r);
    fb_nxt.sq_y       = 62'(s2_ay_r) * 62'(s2_ay_r);
    fb_nxt.sq_r       = 62'(cfg.bump_radius) * 62'(cfg.bump_radius);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r   <= 1'b0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      fb_r.valid <= 1'b0;
    end else begin
      s0_v_r     <= acc_in && (in_word.action != gbs_pkg::ACT_NONE);
      s1_v_r     <= s0_v_r;
      s2_v_r     <= s1_v_r;
      fb_r.valid <= fb_nxt.valid;
    end
    s0_w_r    <= in_word;
    s1_w_r    <= s0_w_r;
    s1_dx_r   <= dx;
    s1_dy_r   <= dy;
    s1_cdx_r  <= cdx;
    s1_cdy_r  <= cdy;
    s2_w_r    <= s1_w_r;
    s2_px_r   <= s1_dx_r[31:0] * cfg.scale_x;
    s2_py_r   <= s1_dy_r[31:0] * cfg.scale_y;
    s2_posx_r <= posx;
    s2_posy_r <= posy;
    s2_inr_r  <= (ax < 33'(cfg.bump_radius)) && (ay < 33'(cfg.bump_radius));
    s2_ax_r   <= ax[30:0];
    s2_ay_r   <= ay[30:0];
    fb_r.action     <= fb_nxt.action;
    fb_r.cell_index <= fb_nxt.cell_index;
    fb_r.cell_value <= fb_nxt.cell_value;
    fb_r.addr_ll    <= fb_nxt.addr_ll;
    fb_r.addr_lr    <= fb_nxt.addr_lr;
    fb_r.addr_ul    <= fb_nxt.addr_ul;
    fb_r.addr_ur    <= fb_nxt.addr_ur;
    fb_r.wx         <= fb_nxt.wx;
    fb_r.wy         <= fb_nxt.wy;
    fb_r.in_range   <= fb_nxt.in_range;
    fb_r.sq_x       <= fb_nxt.sq_x;
    fb_r.sq_y       <= fb_nxt.sq_y;
    fb_r.sq_r       <= fb_nxt.sq_r;
  end

  assign fb = fb_r;

endmodule

>>> sv/gbs_back.sv
// ----------------------------------------------------------------------------
// gbs_back
// Grid store, four neighbor reads, bilinear blend and water-height result.
// ----------------------------------------------------------------------------
module gbs_back #(
  parameter int GRID_W = 256,
  parameter int GRID_H = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gbs_pkg::fb_t       fb,
  output logic               res_push,
  output gbs_pkg::out_word_t res_word
);

  localparam int CELLS = GRID_W * GRID_H;
  localparam int DEPTH = (CELLS > 65536) ? 65536 : CELLS;
  localparam int AW    = $clog2(DEPTH);

  logic        we;
  logic [31:0] rd_ll, rd_lr, rd_ul, rd_ur;
  logic        inc;

  logic        s4_v_r, s4_inc_r;
  logic [1:0]  s4_act_r;
  logic [8:0]  s4_wx_r, s4_wy_r;
  logic signed [9:0]  wy_s, wyc_s, wx_s, wxc_s;
  logic signed [41:0] left, right;

  logic        s5_v_r, s5_inc_r;
  logic [1:0]  s5_act_r;
  logic [8:0]  s5_wx_r;
  logic signed [41:0] s5_left_r, s5_right_r;
  logic signed [52:0] acc;

  logic        s6_v_r, s6_inc_r;
  logic [1:0]  s6_act_r;
  logic signed [52:0] s6_acc_r;
  logic signed [52:0] rnd;
  logic signed [36:0] b;
  logic [36:0] mag;

  assign we = fb.valid && (fb.action == gbs_pkg::ACT_LOAD)
           && (32'(fb.cell_index) < 32'(CELLS));

  gbs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_ll (
    .clk(clk), .we(we), .waddr(AW'(fb.cell_index)), .wdata(fb.cell_value),
    .raddr(AW'(fb.addr_ll)), .rdata(rd_ll));
  gbs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_lr (
    .clk(clk), .we(we), .waddr(AW'(fb.cell_index)), .wdata(fb.cell_value),
    .raddr(AW'(fb.addr_lr)), .rdata(rd_lr));
  gbs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_ul (
    .clk(clk), .we(we), .waddr(AW'(fb.cell_index)), .wdata(fb.cell_value),
    .raddr(AW'(fb.addr_ul)), .rdata(rd_ul));
  gbs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_ur (
    .clk(clk), .we(we), .waddr(AW'(fb.cell_index)), .wdata(fb.cell_value),
    .raddr(AW'(fb.addr_ur)), .rdata(rd_ur));

  // strictly inside the circle
  assign inc = fb.in_range
            && (({1'b0, fb.sq_x} + {1'b0, fb.sq_y}) < {1'b0, fb.sq_r});

  assign wy_s  = $signed({1'b0, s4_wy_r});
  assign wyc_s = 10'sd256 - wy_s;
  assign left  = wy_s * $signed(rd_ul) + wyc_s * $signed(rd_ll);
  assign right = wy_s * $signed(rd_ur) + wyc_s * $signed(rd_lr);

  assign wx_s  = $signed({1'b0, s5_wx_r});
  assign wxc_s = 10'sd256 - wx_s;
  assign acc   = wx_s * s5_right_r + wxc_s * s5_left_r;

  // round half up, back to Q24.8
  assign rnd = s6_acc_r + 53'sd32768;
  assign b   = rnd[52:16];

  always_comb begin
    mag = b[36] ? 37'(-b) : '0;
    res_word.land_error   = 1'b0;
    res_word.sample_value = b[31:0];
    if (s6_act_r == gbs_pkg::ACT_WATER) begin
      if (s6_inc_r && !b[36]) begin
        res_word.land_error   = 1'b1;
        res_word.sample_value = '0;
      end else begin
        if (s6_inc_r) begin
          mag = mag + gbs_pkg::BUMP_HEIGHT;
        end
        res_word.sample_value = (mag > gbs_pkg::SAT_MAX) ? 32'sh7FFF_FFFF
                                                         : $signed(mag[31:0]);
      end
    end
  end

  assign res_push = s6_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else begin
      s4_v_r <= fb.valid && ((fb.action == gbs_pkg::ACT_ELEV)
                          || (fb.action == gbs_pkg::ACT_WATER));
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
    end
    s4_act_r   <= fb.action;
    s4_inc_r   <= inc;
    s4_wx_r    <= fb.wx;
    s4_wy_r    <= fb.wy;
    s5_act_r   <= s4_act_r;
    s5_inc_r   <= s4_inc_r;
    s5_wx_r    <= s4_wx_r;
    s5_left_r  <= left;
    s5_right_r <= right;
    s6_act_r   <= s5_act_r;
    s6_inc_r   <= s5_inc_r;
    s6_acc_r   <= acc;
  end

endmodule

>>> sv/gbs_fifo.sv
// ----------------------------------------------------------------------------
// gbs_fifo
// Result queue; head word is shown while not empty.
// ----------------------------------------------------------------------------
module gbs_fifo #(
  parameter int DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  gbs_pkg::out_word_t     push_word,
  input  logic                   pop,
  output logic                   empty,
  output logic                   fifo_full,
  output logic [$clog2(DEPTH):0] count,
  output gbs_pkg::out_word_t     head
);

  localparam int PW = $clog2(DEPTH);

  gbs_pkg::out_word_t mem [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [PW:0]   cnt_r;
  logic          do_pop;

  assign empty     = (cnt_r == '0);
  assign fifo_full = (cnt_r == (PW+1)'(DEPTH));
  assign count     = cnt_r;
  assign head      = mem[rd_r];
  assign do_pop    = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(do_pop);
    end
    if (push) begin
      mem[wr_r] <= push_word;
    end
  end

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// grid_bilinear_sampler_core testbench
// Preloads the grid corners, then runs directed and random loads,
// elevation and water-height queries over several area, scale and circle
// settings. Every result word is checked in order against a local predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GW = 256;
  localparam int GH = 256;
  localparam int PRE = 16;
  localparam int N_PHASES = 9;
  localparam int PHASE_ITEMS = 94;
  localparam int LATENCY = 12;

  // Keeps the grid and register copies, predicts each query, checks results.
  class sample_scoreboard;
    int                 elev[GW*GH];
    bit                 loaded[GW*GH];
    logic signed [31:0] org_x, org_y, ctr_x, ctr_y;
    logic        [31:0] scl_x, scl_y;
    logic        [30:0] radius;
    gbs_pkg::out_word_t pending_q[$];
    int                 errors;
    int                 checked;

    function new();
      org_x = 0; org_y = 0; scl_x = 0; scl_y = 0;
      ctr_x = 0; ctr_y = 0; radius = 0;
      errors = 0; checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        gbs_pkg::CFG_AREA_MIN_X:    org_x = d;
        gbs_pkg::CFG_AREA_MIN_Y:    org_y = d;
        gbs_pkg::CFG_SCALE_X:       scl_x = d;
        gbs_pkg::CFG_SCALE_Y:       scl_y = d;
        gbs_pkg::CFG_BUMP_CENTER_X: ctr_x = d;
        gbs_pkg::CFG_BUMP_CENTER_Y: ctr_y = d;
        gbs_pkg::CFG_BUMP_RADIUS:   radius = d[30:0];
        default: ;
      endcase
    endfunction

    // grid units with 8 fraction bits, saturated at the grid edge
    function longint unsigned grid_pos(longint q, longint mn, longint unsigned scl,
                                       longint unsigned size);
      longint          d;
      longint unsigned ud, lim;
      d = q - mn;
      if (d <= 0 || scl == 0) return 0;
      ud  = longint'(d);
      lim = size << 32;
      if (ud >= (lim + scl - 1) / scl) return size << 8;
      return (ud * scl) >> 24;
    endfunction

    // true when all four neighbors of the point have been loaded
    function bit covered(logic signed [31:0] qx, logic signed [31:0] qy);
      longint unsigned cx, cy, lx, rx, ly, uy;
      cx = grid_pos(longint'(qx), longint'(org_x), scl_x, GW);
      cy = grid_pos(longint'(qy), longint'(org_y), scl_y, GH);
      lx = cx >> 8; rx = lx + ((cx & 8'hFF) != 0);
      ly = cy >> 8; uy = ly + ((cy & 8'hFF) != 0);
      if (lx >= GW) lx = GW - 1;
      if (rx >= GW) rx = GW - 1;
      if (ly >= GH) ly = GH - 1;
      if (uy >= GH) uy = GH - 1;
      return loaded[ly*GW+lx] && loaded[ly*GW+rx] && loaded[uy*GW+lx]
          && loaded[uy*GW+rx];
    endfunction

    function longint blend_at(longint qx, longint qy);
      longint unsigned cx, cy, lx, rx, ly, uy;
      longint          wx, wy, left, right, acc;
      cx = grid_pos(qx, longint'(org_x), scl_x, GW);
      cy = grid_pos(qy, longint'(org_y), scl_y, GH);
      lx = cx >> 8; rx = lx + ((cx & 8'hFF) != 0);
      ly = cy >> 8; uy = ly + ((cy & 8'hFF) != 0);
      if (lx >= GW) lx = GW - 1;
      if (rx >= GW) rx = GW - 1;
      if (ly >= GH) ly = GH - 1;
      if (uy >= GH) uy = GH - 1;
      wx = longint'(cx) - longint'(lx << 8);
      wy = longint'(cy) - longint'(ly << 8);
      left  = wy * longint'(elev[uy*GW+lx]) + (256 - wy) * longint'(elev[ly*GW+lx]);
      right = wy * longint'(elev[uy*GW+rx]) + (256 - wy) * longint'(elev[ly*GW+rx]);
      acc = wx * right + (256 - wx) * left;
      return (acc + 32768) >>> 16;
    endfunction

    function bit in_bump(longint qx, longint qy);
      longint          dx, dy;
      longint unsigned ax, ay, r;
      dx = qx - longint'(ctr_x);
      dy = qy - longint'(ctr_y);
      r  = radius;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      if (ax >= r || ay >= r) return 0;
      return ax * ax + ay * ay < r * r;
    endfunction

    function void note_input(gbs_pkg::in_word_t w);
      longint             b, v;
      gbs_pkg::out_word_t e;
      if (w.action == gbs_pkg::ACT_LOAD) begin
        elev[w.cell_index] = w.cell_value;
        loaded[w.cell_index] = 1'b1;
        return;
      end
      if (w.action == gbs_pkg::ACT_NONE) return;
      b = blend_at(w.query_x, w.query_y);
      e.land_error = 1'b0;
      if (w.action == gbs_pkg::ACT_ELEV) begin
        e.sample_value = b[31:0];
      end else begin
        v = b < 0 ? -b : 0;
        if (in_bump(w.query_x, w.query_y)) begin
          if (b >= 0) begin
            e.land_error = 1'b1;
            v = 0;
          end else begin
            v = v + longint'(gbs_pkg::BUMP_HEIGHT);
          end
        end
        if (v > longint'(gbs_pkg::SAT_MAX)) v = longint'(gbs_pkg::SAT_MAX);
        e.sample_value = v[31:0];
      end
      pending_q.push_back(e);
    endfunction

    function void check_result(gbs_pkg::out_word_t got);
      gbs_pkg::out_word_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result word: sample_value %0d land_error %0b",
               got.sample_value, got.land_error);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (got.sample_value !== e.sample_value) begin
        $error("sample_value: expected %0d, got %0d", e.sample_value, got.sample_value);
        errors++;
      end
      if (got.land_error !== e.land_error) begin
        $error("land_error: expected %0b, got %0b", e.land_error, got.land_error);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  gbs_pkg::in_word_t  in_word = '0;
  logic               empty;
  logic               pop = 1'b0;
  gbs_pkg::out_word_t out_word;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  sample_scoreboard sb = new();
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          n_loads = 0;
  longint      span = 65536;
  bit          wide_queries = 0;

  always #6 clk = ~clk;

  grid_bilinear_sampler_core uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_word(in_word),
    .empty(empty), .pop(pop), .out_word(out_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_result(out_word);
  end

  initial begin
    #20_000_000;
    $display("grid_bilinear_sampler_core regression: fail");
    $finish;
  end

  function automatic gbs_pkg::in_word_t mk(logic [1:0] a, logic [15:0] idx,
                                           logic [31:0] val, logic [31:0] qx,
                                           logic [31:0] qy);
    gbs_pkg::in_word_t w;
    w.action = a; w.cell_index = idx; w.cell_value = val;
    w.query_x = qx; w.query_y = qy;
    return w;
  endfunction

  task automatic send(gbs_pkg::in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push    <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_input(w);
    if (w.action == gbs_pkg::ACT_LOAD) n_loads++;
  endtask

  // quiet the input side and let every pending word come out
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] mx, logic [31:0] my, logic [31:0] sx,
                           logic [31:0] sy, logic [31:0] cx, logic [31:0] cy,
                           logic [31:0] r);
    write_reg(gbs_pkg::CFG_AREA_MIN_X, mx);
    write_reg(gbs_pkg::CFG_AREA_MIN_Y, my);
    write_reg(gbs_pkg::CFG_SCALE_X, sx);
    write_reg(gbs_pkg::CFG_SCALE_Y, sy);
    write_reg(gbs_pkg::CFG_BUMP_CENTER_X, cx);
    write_reg(gbs_pkg::CFG_BUMP_CENTER_Y, cy);
    write_reg(gbs_pkg::CFG_BUMP_RADIUS, r);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(4000)) - 2000);
      default: return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
    endcase
  endfunction

  function automatic logic [31:0] near(logic signed [31:0] org);
    return 32'(longint'(org) + longint'($urandom_range(32'(span + span / 4)))
               - span / 8);
  endfunction

  task automatic random_item();
    int          sel;
    int          tries;
    logic [1:0]  a;
    logic [31:0] qx, qy;
    longint      r;
    sel = $urandom_range(99);
    if (sel < 20) begin
      send(mk(gbs_pkg::ACT_LOAD, $urandom, rand_value(), $urandom, $urandom));
      return;
    end
    if (sel < 23) begin
      send(mk(gbs_pkg::ACT_NONE, $urandom, $urandom, $urandom, $urandom));
      return;
    end
    a = (sel < 55) ? gbs_pkg::ACT_ELEV : gbs_pkg::ACT_WATER;
    r = sb.radius;
    tries = 0;
    // only points whose four neighbors are loaded
    do begin
      if (wide_queries || $urandom_range(9) == 0) begin
        qx = $urandom; qy = $urandom;
      end else if (a == gbs_pkg::ACT_WATER && $urandom_range(9) < 4) begin
        qx = 32'(longint'(sb.ctr_x) + longint'($urandom_range(32'(2 * r + 2))) - r - 1);
        qy = 32'(longint'(sb.ctr_y) + longint'($urandom_range(32'(2 * r + 2))) - r - 1);
      end else begin
        qx = near(sb.org_x); qy = near(sb.org_y);
      end
      tries++;
    end while (!sb.covered(qx, qy) && tries < 16);
    if (!sb.covered(qx, qy)) begin
      // most negative point always maps to the first cell
      qx = 32'h8000_0000; qy = 32'h8000_0000;
    end
    send(mk(a, $urandom, $urandom, qx, qy));
  endtask

  initial begin
    logic signed [31:0] ox, oy;
    longint             scl;
    int                 k, j, p;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // low corner block plus the last row and column next to it
    for (k = 0; k < PRE; k++) begin
      for (j = 0; j < PRE; j++) begin
        send(mk(gbs_pkg::ACT_LOAD, 16'(k * GW + j), rand_value(), 0, 0));
      end
    end
    for (k = 0; k < PRE; k++) begin
      send(mk(gbs_pkg::ACT_LOAD, 16'(k * GW + GW - 1), rand_value(), 0, 0));
      send(mk(gbs_pkg::ACT_LOAD, 16'((GH - 1) * GW + k), rand_value(), 0, 0));
    end
    send(mk(gbs_pkg::ACT_LOAD, 16'(GH * GW - 1), rand_value(), 0, 0));

    // directed: unit scale, origin 0, so grid point (gx, gy) sits at gx*256
    drain();
    write_all(0, 0, 32'h0100_0000, 32'h0100_0000, 8 * 256, 8 * 256, 4 * 256);
    send(mk(gbs_pkg::ACT_LOAD, 16'(8 * GW + 8), 1000, 0, 0));
    send(mk(gbs_pkg::ACT_WATER, 0, 0, 8 * 256, 8 * 256));         // land inside circle
    send(mk(gbs_pkg::ACT_ELEV, 0, 0, 8 * 256, 8 * 256));
    send(mk(gbs_pkg::ACT_LOAD, 16'(8 * GW + 8), -32'sd5000, 0, 0));
    send(mk(gbs_pkg::ACT_WATER, 0, 0, 8 * 256, 8 * 256));         // sea inside circle
    send(mk(gbs_pkg::ACT_WATER, 0, 0, 12 * 256, 8 * 256));        // on the rim: outside
    send(mk(gbs_pkg::ACT_ELEV, 0, 0, 8 * 256 + 128, 8 * 256 + 64));
    send(mk(gbs_pkg::ACT_LOAD, 16'hFFFF, 32'h8000_0000, 0, 0));
    send(mk(gbs_pkg::ACT_WATER, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF)); // deepest corner
    send(mk(gbs_pkg::ACT_ELEV, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send(mk(gbs_pkg::ACT_LOAD, 16'hFFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(mk(gbs_pkg::ACT_ELEV, 0, 0, 255 * 256 + 200, 255 * 256 + 200));
    send(mk(gbs_pkg::ACT_LOAD, 0, 32'h8000_0000, 0, 0));
    send(mk(gbs_pkg::ACT_ELEV, 0, 0, 32'h8000_0000, 32'h8000_0000));
    send(mk(gbs_pkg::ACT_WATER, 0, 0, 0, 0));
    send(mk(gbs_pkg::ACT_NONE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(mk(gbs_pkg::ACT_ELEV, 0, 0, 256 * 256, 0));
    send(mk(gbs_pkg::ACT_ELEV, 0, 0, 0, 256 * 256 - 1));
    send(mk(gbs_pkg::ACT_WATER, 0, 0, 32'h0000_0E7F, 32'hFFFF_8000));

    for (p = 0; p < N_PHASES; p++) begin
      drain();
      wide_queries = 0;
      case (p)
        1: begin
          wide_queries = 1;
          write_all(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        end
        2: begin
          wide_queries = 1;
          write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000,
                    32'h7FFF_FFFF, 0);
        end
        default: begin
          // the span covers about the loaded corner block
          span = longint'(1) << $urandom_range(10, 27);
          span = span + $urandom_range(32'(span));
          scl  = (longint'(1) << 36) / span;
          ox   = 32'($signed($urandom_range(1 << 30)) - (1 << 29));
          oy   = 32'($signed($urandom_range(1 << 30)) - (1 << 29));
          write_all(ox, oy, 32'(scl), 32'(scl + $urandom_range(3)),
                    32'(longint'(ox) + $urandom_range(32'(span))),
                    32'(longint'(oy) + $urandom_range(32'(span))),
                    32'($urandom_range(32'(span / 3))));
        end
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) random_item();
    end

    drain();
    $display("covered %0d query results and %0d cell loads over %0d register settings",
             sb.checked, n_loads, N_PHASES + 1);
    $display("idle and stall mixes: none, sender 66%%, receiver 66%%, both 19%%");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("grid_bilinear_sampler_core regression: pass");
    end else begin
      $display("grid_bilinear_sampler_core regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/gbs_pkg.sv
sv/gbs_ram.sv
sv/gbs_front.sv
sv/gbs_back.sv
sv/gbs_fifo.sv
sv/grid_bilinear_sampler_core.sv
dv/testbench.sv
